// File: rtl/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared constants and types for the depth pixel to point back-projection.
// ----------------------------------------------------------------------------
package dpp_pkg;

    // default coordinate width of column and row
    localparam int COORD_BITS_DEF = 11;

    // configuration register widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PIX_W      = 20;
    localparam int SCALE_W    = 24;

    // field widths
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 24;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_FOCAL_X     = 3'd2,
        CFG_FOCAL_Y     = 3'd3,
        CFG_DEPTH_SCALE = 3'd4
    } t_cfg_idx;

    // reset values
    localparam logic [PIX_W-1:0]   RST_CENTER_X    = 20'd81792;
    localparam logic [PIX_W-1:0]   RST_CENTER_Y    = 20'd61312;
    localparam logic [PIX_W-1:0]   RST_FOCAL_X     = 20'd134400;
    localparam logic [PIX_W-1:0]   RST_FOCAL_Y     = 20'd134400;
    localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 24'd1280000;

    // saturation limits
    localparam logic [COORD_W-1:0] XY_POS_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] XY_NEG_MIN = 24'h800000;
    localparam logic [COORD_W-1:0] Z_MAX      = 24'hFFFFFF;

    // per-axis flags handed to the output stage
    typedef struct packed {
        logic neg;
        logic zero;
        logic sat;
    } t_axis_flags;

endpackage

// File: rtl/dpp_divider.sv
// ----------------------------------------------------------------------------
// dpp_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module dpp_divider #(
    parameter int QW = 24,
    parameter int DW = 24,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_acc  [QW];
    logic [SW-1:0] r_side [QW];

    logic          w_vld  [QW];
    logic [DW-1:0] w_rem  [QW];
    logic [QW-1:0] w_acc  [QW];
    logic [SW-1:0] w_side [QW];

    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_acc  [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [DW:0] w_shift;
            logic        w_ge;

            // stage input: ports for the first, previous stage otherwise
            if (k == 0) begin : g_first
                assign w_vld[k]  = i_vld;
                assign w_rem[k]  = i_rem;
                assign w_acc[k]  = i_low;
                assign w_side[k] = i_side;
            end else begin : g_next
                assign w_vld[k]  = r_vld[k-1];
                assign w_rem[k]  = r_rem[k-1];
                assign w_acc[k]  = r_acc[k-1];
                assign w_side[k] = r_side[k-1];
            end

            // one trial subtract
            always_comb begin
                w_shift  = {w_rem[k], w_acc[k][QW-1]};
                w_ge     = (w_shift >= {1'b0, i_div});
                n_rem[k] = w_ge ? w_shift[DW-1:0] - i_div : w_shift[DW-1:0];
                n_acc[k] = {w_acc[k][QW-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= w_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem[k];
                    r_acc[k]  <= n_acc[k];
                    r_side[k] <= w_side[k];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_acc[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// File: rtl/depth_pixel_to_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Pinhole back-projection of one depth pixel into a colored 3D point.
// ----------------------------------------------------------------------------
// pipeline from input word to output word: input stage, 24-stage depth
//   divider, offset, multiply and flag stages, 24-stage x/y dividers,
//   output register; throughput one pixel per cycle, set by the pipelined
//   bit-per-stage dividers; the whole pipe holds while the output is stalled
// reset: synchronous active low, clears valid bits and loads default camera
//   registers; pixels with zero depth are accepted and dropped
module depth_pixel_to_point #(
    parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF,
    localparam int IN_RAW_W  = 2 * COORD_BITS + dpp_pkg::DEPTH_W + dpp_pkg::COLOR_W,
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8,
    localparam int OUT_W     = 3 * dpp_pkg::COORD_W + dpp_pkg::COLOR_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [dpp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dpp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // column, row, depth_raw, blue, green, red
    // point output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata   // point_x, point_y, point_z, out_blue, out_green, out_red
);

    localparam int CB    = COORD_BITS;
    localparam int PW    = dpp_pkg::PIX_W;
    localparam int SCW   = dpp_pkg::SCALE_W;
    localparam int DPW   = dpp_pkg::DEPTH_W;
    localparam int CLW   = dpp_pkg::COLOR_W;
    localparam int ZW    = dpp_pkg::COORD_W;
    localparam int MAG_W = (CB + 8 > PW) ? CB + 8 : PW;
    localparam int NUM_W = MAG_W + ZW;
    localparam int ZS_W  = 2 * CB + CLW + 1;
    localparam int XS_W  = CLW + ZW + 3;

    // configuration registers
    logic [PW-1:0]  r_center_x, r_center_y, r_focal_x, r_focal_y;
    logic [SCW-1:0] r_depth_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= dpp_pkg::RST_CENTER_X;
            r_center_y    <= dpp_pkg::RST_CENTER_Y;
            r_focal_x     <= dpp_pkg::RST_FOCAL_X;
            r_focal_y     <= dpp_pkg::RST_FOCAL_Y;
            r_depth_scale <= dpp_pkg::RST_DEPTH_SCALE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                dpp_pkg::CFG_CENTER_X:    r_center_x    <= i_cfg_wdata[PW-1:0];
                dpp_pkg::CFG_CENTER_Y:    r_center_y    <= i_cfg_wdata[PW-1:0];
                dpp_pkg::CFG_FOCAL_X:     r_focal_x     <= i_cfg_wdata[PW-1:0];
                dpp_pkg::CFG_FOCAL_Y:     r_focal_y     <= i_cfg_wdata[PW-1:0];
                dpp_pkg::CFG_DEPTH_SCALE: r_depth_scale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves unless the output word is stalled
    logic r_out_vld;
    logic w_en;
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // input field unpack
    logic [CB-1:0]  w_col, w_row;
    logic [DPW-1:0] w_depth;
    logic [CLW-1:0] w_color;
    assign w_col   = s_axis_tdata[CB-1:0];
    assign w_row   = s_axis_tdata[2*CB-1:CB];
    assign w_depth = s_axis_tdata[2*CB+DPW-1:2*CB];
    assign w_color = s_axis_tdata[2*CB+DPW+CLW-1:2*CB+DPW];

    // stage 0: input register, zero depth drops the word
    logic           r_s0_vld;
    logic [CB-1:0]  r_s0_col, r_s0_row;
    logic [DPW-1:0] r_s0_depth;
    logic [CLW-1:0] r_s0_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= s_axis_tvalid && (w_depth != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_col   <= w_col;
            r_s0_row   <= w_row;
            r_s0_depth <= w_depth;
            r_s0_color <= w_color;
        end
    end

    // quotient of depth*2^24/scale overflows 24 bits exactly when depth >= scale
    logic           w_z_sat;
    logic [SCW-1:0] w_z_rem;
    assign w_z_sat = ({{(SCW-DPW){1'b0}}, r_s0_depth} >= r_depth_scale);
    assign w_z_rem = w_z_sat ? '0 : {{(SCW-DPW){1'b0}}, r_s0_depth};

    // depth divider
    logic            w_dz_vld;
    logic [ZW-1:0]   w_dz_quo;
    logic [ZS_W-1:0] w_dz_side;

    dpp_divider #(
        .QW (ZW),
        .DW (SCW),
        .SW (ZS_W)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_rem   (w_z_rem),
        .i_low   ('0),
        .i_div   (r_depth_scale),
        .i_side  ({w_z_sat, r_s0_color, r_s0_row, r_s0_col}),
        .o_vld   (w_dz_vld),
        .o_quo   (w_dz_quo),
        .o_side  (w_dz_side)
    );

    logic [CB-1:0]  w_dz_col, w_dz_row;
    logic [CLW-1:0] w_dz_color;
    logic           w_dz_sat;
    logic [ZW-1:0]  w_zq;
    assign w_dz_col   = w_dz_side[CB-1:0];
    assign w_dz_row   = w_dz_side[2*CB-1:CB];
    assign w_dz_color = w_dz_side[2*CB+CLW-1:2*CB];
    assign w_dz_sat   = w_dz_side[ZS_W-1];
    assign w_zq       = w_dz_sat ? dpp_pkg::Z_MAX : w_dz_quo;

    // stage 1: offset from the principal point, sign and magnitude
    logic [MAG_W:0] w_pos_x, w_pos_y, w_cen_x, w_cen_y;
    logic           w_neg_x, w_neg_y;
    logic [MAG_W:0] w_dif_x, w_dif_y;

    always_comb begin
        w_pos_x = {{(MAG_W-CB-8+1){1'b0}}, w_dz_col, 8'd0};
        w_pos_y = {{(MAG_W-CB-8+1){1'b0}}, w_dz_row, 8'd0};
        w_cen_x = {{(MAG_W-PW+1){1'b0}}, r_center_x};
        w_cen_y = {{(MAG_W-PW+1){1'b0}}, r_center_y};
        w_neg_x = (w_pos_x < w_cen_x);
        w_neg_y = (w_pos_y < w_cen_y);
        w_dif_x = w_neg_x ? w_cen_x - w_pos_x : w_pos_x - w_cen_x;
        w_dif_y = w_neg_y ? w_cen_y - w_pos_y : w_pos_y - w_cen_y;
    end

    logic             r_s1_vld;
    logic [MAG_W-1:0] r_s1_mag_x, r_s1_mag_y;
    logic             r_s1_neg_x, r_s1_neg_y;
    logic [ZW-1:0]    r_s1_zq;
    logic [CLW-1:0]   r_s1_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= w_dz_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_mag_x <= w_dif_x[MAG_W-1:0];
            r_s1_mag_y <= w_dif_y[MAG_W-1:0];
            r_s1_neg_x <= w_neg_x;
            r_s1_neg_y <= w_neg_y;
            r_s1_zq    <= w_zq;
            r_s1_color <= w_dz_color;
        end
    end

    // stage 2: offset times depth
    logic             r_s2_vld;
    logic [NUM_W-1:0] r_s2_num_x, r_s2_num_y;
    logic             r_s2_neg_x, r_s2_neg_y;
    logic [ZW-1:0]    r_s2_zq;
    logic [CLW-1:0]   r_s2_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_num_x <= NUM_W'(r_s1_mag_x) * NUM_W'(r_s1_zq);
            r_s2_num_y <= NUM_W'(r_s1_mag_y) * NUM_W'(r_s1_zq);
            r_s2_neg_x <= r_s1_neg_x;
            r_s2_neg_y <= r_s1_neg_y;
            r_s2_zq    <= r_s1_zq;
            r_s2_color <= r_s1_color;
        end
    end

    // stage 3: zero and overflow flags, divider seed
    logic                r_s3_vld;
    dpp_pkg::t_axis_flags r_s3_fx, r_s3_fy;
    logic [PW-1:0]       r_s3_rem_x, r_s3_rem_y;
    logic [ZW-1:0]       r_s3_low_x, r_s3_low_y;
    logic [ZW-1:0]       r_s3_zq;
    logic [CLW-1:0]      r_s3_color;

    logic [MAG_W-1:0] w_hi_x, w_hi_y;
    logic             w_ov_x, w_ov_y;
    assign w_hi_x = r_s2_num_x[NUM_W-1:ZW];
    assign w_hi_y = r_s2_num_y[NUM_W-1:ZW];
    assign w_ov_x = (w_hi_x >= MAG_W'(r_focal_x));
    assign w_ov_y = (w_hi_y >= MAG_W'(r_focal_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_fx    <= '{neg: r_s2_neg_x, zero: (r_s2_num_x == '0), sat: w_ov_x};
            r_s3_fy    <= '{neg: r_s2_neg_y, zero: (r_s2_num_y == '0), sat: w_ov_y};
            r_s3_rem_x <= w_ov_x ? '0 : w_hi_x[PW-1:0];
            r_s3_rem_y <= w_ov_y ? '0 : w_hi_y[PW-1:0];
            r_s3_low_x <= r_s2_num_x[ZW-1:0];
            r_s3_low_y <= r_s2_num_y[ZW-1:0];
            r_s3_zq    <= r_s2_zq;
            r_s3_color <= r_s2_color;
        end
    end

    // x and y dividers run in lockstep
    logic            w_dx_vld, w_dy_vld;
    logic [ZW-1:0]   w_dx_quo, w_dy_quo;
    logic [XS_W-1:0] w_dx_side;
    logic [2:0]      w_dy_side;

    dpp_divider #(
        .QW (ZW),
        .DW (PW),
        .SW (XS_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_rem   (r_s3_rem_x),
        .i_low   (r_s3_low_x),
        .i_div   (r_focal_x),
        .i_side  ({r_s3_fx, r_s3_zq, r_s3_color}),
        .o_vld   (w_dx_vld),
        .o_quo   (w_dx_quo),
        .o_side  (w_dx_side)
    );

    dpp_divider #(
        .QW (ZW),
        .DW (PW),
        .SW (3)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_rem   (r_s3_rem_y),
        .i_low   (r_s3_low_y),
        .i_div   (r_focal_y),
        .i_side  (r_s3_fy),
        .o_vld   (w_dy_vld),
        .o_quo   (w_dy_quo),
        .o_side  (w_dy_side)
    );

    dpp_pkg::t_axis_flags w_fx, w_fy;
    logic [ZW-1:0]        w_out_zq;
    logic [CLW-1:0]       w_out_color;
    assign w_out_color = w_dx_side[CLW-1:0];
    assign w_out_zq    = w_dx_side[CLW+ZW-1:CLW];
    assign w_fx        = w_dx_side[XS_W-1:CLW+ZW];
    assign w_fy        = w_dy_side;

    // signed saturation of one coordinate
    function automatic logic [ZW-1:0] clamp_axis(
        input logic [ZW-1:0]        q,
        input dpp_pkg::t_axis_flags f
    );
        logic [ZW-1:0] res;
        if (f.zero) begin
            res = '0;
        end else if (f.neg) begin
            res = (f.sat || q > dpp_pkg::XY_NEG_MIN) ? dpp_pkg::XY_NEG_MIN : ~q + 1'b1;
        end else begin
            res = (f.sat || q[ZW-1]) ? dpp_pkg::XY_POS_MAX : q;
        end
        return res;
    endfunction

    // output register
    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {w_out_color, w_out_zq,
                           clamp_axis(w_dy_quo, w_fy), clamp_axis(w_dx_quo, w_fx)};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // a delivered point always has nonzero depth
    a_z_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3*ZW-1:2*ZW] != '0))
        else $error("point with zero depth delivered");

    // a word held in the first stage never carries zero depth
    a_s0_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_vld |-> (r_s0_depth != '0))
        else $error("zero depth word entered the pipe");

    // x and y dividers stay in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dx_vld == w_dy_vld)
        else $error("x and y dividers out of step");

endmodule

// File: tb/depth_pixel_to_point_test.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point_test
// Streams depth pixels through the back-projection block under several camera
// settings, with random gaps on both sides, and checks each point word field
// by field against a fixed-point predictor of the pinhole model.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_test;

    localparam int CB        = dpp_pkg::COORD_BITS_DEF;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 96;
    localparam int PIX_BITS  = 2 * CB + 16 + 24;
    localparam int LATENCY   = 53;
    localparam int N_RANDOM  = 88;

    // register indexes that no register answers to
    localparam logic [dpp_pkg::CFG_ADDR_W-1:0] IDX_SPARE_LO = 3'd5;
    localparam logic [dpp_pkg::CFG_ADDR_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] depth;
        logic [CB-1:0] row;
        logic [CB-1:0] column;
    } t_pixel;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] z;
        logic [23:0] y;
        logic [23:0] x;
    } t_point;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [dpp_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [dpp_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;  // column, row, depth_raw, blue, green, red
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;       // point_x, point_y, point_z, out_blue, out_green, out_red

    // camera settings as the block should hold them
    logic [dpp_pkg::PIX_W-1:0]   cam_cx, cam_cy, cam_fx, cam_fy;
    logic [dpp_pkg::SCALE_W-1:0] cam_scale;

    t_point pending_points[$];
    int     errors = 0;

    depth_pixel_to_point dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one axis of the back-projection, as a 24-bit two's complement pattern
    function automatic logic [23:0] project_axis(logic [CB-1:0] coord,
                                                 logic [dpp_pkg::PIX_W-1:0] center,
                                                 logic [dpp_pkg::PIX_W-1:0] focal,
                                                 logic [23:0] zq);
        logic [63:0] pos, mag, num, quo;
        logic        neg;
        pos = 64'(coord) << 8;
        neg = pos < 64'(center);
        mag = neg ? 64'(center) - pos : pos - 64'(center);
        num = mag * 64'(zq);
        if (num == 0) return '0;
        quo = (focal == 0) ? 64'd8388609 : num / 64'(focal);
        if (neg) begin
            if (quo > 64'd8388608) quo = 64'd8388608;
            return 24'(-quo);
        end
        if (quo > 64'd8388607) quo = 64'd8388607;
        return quo[23:0];
    endfunction

    // expected point for one pixel; returns 0 when the pixel is dropped
    function automatic bit back_project(t_pixel px, output t_point pt);
        logic [63:0] zq;
        if (px.depth == 0) return 0;
        zq = (cam_scale == 0) ? 64'hFFFFFF : (64'(px.depth) << 24) / 64'(cam_scale);
        if (zq > 64'hFFFFFF) zq = 64'hFFFFFF;
        pt.x     = project_axis(px.column, cam_cx, cam_fx, zq[23:0]);
        pt.y     = project_axis(px.row, cam_cy, cam_fy, zq[23:0]);
        pt.z     = zq[23:0];
        pt.blue  = px.blue;
        pt.green = px.green;
        pt.red   = px.red;
        return 1;
    endfunction

    // output side: random backpressure and field-by-field compare
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_points.size() == 0) begin
                $error("point word with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (got.x !== want.x) begin
                    $error("point_x expected %h got %h", want.x, got.x); errors++;
                end
                if (got.y !== want.y) begin
                    $error("point_y expected %h got %h", want.y, got.y); errors++;
                end
                if (got.z !== want.z) begin
                    $error("point_z expected %h got %h", want.z, got.z); errors++;
                end
                if (got.blue !== want.blue) begin
                    $error("out_blue expected %h got %h", want.blue, got.blue); errors++;
                end
                if (got.green !== want.green) begin
                    $error("out_green expected %h got %h", want.green, got.green); errors++;
                end
                if (got.red !== want.red) begin
                    $error("out_red expected %h got %h", want.red, got.red); errors++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    // send one pixel word, with a random gap ahead of it
    task automatic send_pixel(t_pixel px);
        int     gap;
        t_point pt;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(px);
        do @(posedge i_clk); while (!s_axis_tready);
        if (back_project(px, pt)) pending_points.insert(pending_points.size(), pt);
    endtask

    // let every expected point out, then let the pipe empty of dropped pixels
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // register write, mirrored into the predictor's copy
    task automatic write_reg(dpp_pkg::t_cfg_idx idx, logic [dpp_pkg::CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            dpp_pkg::CFG_CENTER_X:    cam_cx = value[dpp_pkg::PIX_W-1:0];
            dpp_pkg::CFG_CENTER_Y:    cam_cy = value[dpp_pkg::PIX_W-1:0];
            dpp_pkg::CFG_FOCAL_X:     cam_fx = value[dpp_pkg::PIX_W-1:0];
            dpp_pkg::CFG_FOCAL_Y:     cam_fy = value[dpp_pkg::PIX_W-1:0];
            dpp_pkg::CFG_DEPTH_SCALE: cam_scale = value[dpp_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [23:0] cx, logic [23:0] cy, logic [23:0] fx,
                              logic [23:0] fy, logic [23:0] sc);
        write_reg(dpp_pkg::CFG_CENTER_X, cx);
        write_reg(dpp_pkg::CFG_CENTER_Y, cy);
        write_reg(dpp_pkg::CFG_FOCAL_X, fx);
        write_reg(dpp_pkg::CFG_FOCAL_Y, fy);
        write_reg(dpp_pkg::CFG_DEPTH_SCALE, sc);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel px;
        int roll;
        px = PIX_BITS'({$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < 8)       px.depth = 16'd0;
        else if (roll < 13) px.depth = 16'hFFFF;
        else if (roll < 18) px.depth = 16'(1 + $urandom_range(0, 15));
        else                px.depth = 16'($urandom_range(1, 65535));
        return px;
    endfunction

    task automatic random_run(int count);
        for (int i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    // directed pixels under the reset camera; zero-depth rows must give no point
    t_pixel directed[] = '{
        '{red: 8'h00, green: 8'h00, blue: 8'h00, depth: 16'd0,     row: 11'd0,    column: 11'd0},
        '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, depth: 16'd0,     row: 11'd2047, column: 11'd2047},
        '{red: 8'h00, green: 8'h00, blue: 8'h00, depth: 16'd1,     row: 11'd0,    column: 11'd0},
        '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, depth: 16'hFFFF,  row: 11'd2047, column: 11'd2047},
        '{red: 8'hFF, green: 8'h00, blue: 8'hAA, depth: 16'hFFFF,  row: 11'd0,    column: 11'd0},
        '{red: 8'h55, green: 8'hAA, blue: 8'h55, depth: 16'd1000,  row: 11'd239,  column: 11'd319},
        '{red: 8'h12, green: 8'h34, blue: 8'h56, depth: 16'd1000,  row: 11'd240,  column: 11'd320},
        '{red: 8'h01, green: 8'h80, blue: 8'h7F, depth: 16'h5555,  row: 11'h555,  column: 11'h2AA},
        '{red: 8'hFE, green: 8'h7F, blue: 8'h80, depth: 16'hAAAA,  row: 11'h2AA,  column: 11'h555},
        '{red: 8'h00, green: 8'hFF, blue: 8'h00, depth: 16'h8000,  row: 11'd1024, column: 11'd1},
        '{red: 8'h33, green: 8'h66, blue: 8'h99, depth: 16'd40000, row: 11'd480,  column: 11'd640}
    };

    initial begin
        cam_cx    = dpp_pkg::RST_CENTER_X;
        cam_cy    = dpp_pkg::RST_CENTER_Y;
        cam_fx    = dpp_pkg::RST_FOCAL_X;
        cam_fy    = dpp_pkg::RST_FOCAL_Y;
        cam_scale = dpp_pkg::RST_DEPTH_SCALE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset settings
        foreach (directed[i]) send_pixel(directed[i]);
        random_run(N_RANDOM);
        // sender holds off until every point is out
        drain();
        random_run(N_RANDOM / 2);
        drain();

        // smallest legal settings: z and every nonzero offset saturate
        set_camera(24'd0, 24'd0, 24'd1, 24'd1, 24'd1);
        random_run(N_RANDOM / 2);
        drain();

        // largest settings, upper bits of the 20-bit registers written too
        set_camera(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_run(N_RANDOM / 2);
        drain();

        // zero focal lengths and zero depth scale
        set_camera(24'd81920, 24'd61440, 24'd0, 24'd0, 24'd0);
        random_run(N_RANDOM / 2);
        drain();

        // unit scale, realistic optics, then an unused index that must be ignored
        set_camera(24'd81792, 24'd61312, 24'd134400, 24'd134400, 24'd256);
        write_reg(dpp_pkg::t_cfg_idx'(IDX_SPARE_LO), 24'h000001);
        write_reg(dpp_pkg::t_cfg_idx'(IDX_SPARE_HI), 24'hFFFFFF);
        random_run(N_RANDOM);
        drain();

        // random settings, mostly near a usable camera
        for (int k = 0; k < 3; k++) begin
            set_camera(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 524287)),
                       24'($urandom_range(1, 400000)), 24'($urandom_range(1, 400000)),
                       24'($urandom_range(1, 24'hFFFFFF)));
            random_run(N_RANDOM / 2);
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
